// ----- rtl/tsl_pkg.sv -----
// ============================================================================
// tsl_pkg
// Shared types, constants and helpers of the triangle slope limiter.
// ============================================================================
package tsl_pkg;

    localparam int unsigned   QW       = 32;
    localparam int unsigned   GAIN_W   = 18;
    localparam int unsigned   PHI_W    = 17;
    localparam int unsigned   QUOT_W   = 16;
    localparam int unsigned   WIDE_W   = 36;
    localparam int unsigned   QDEPTH   = 4;
    localparam int unsigned   QPTR_W   = 2;
    localparam logic [16:0]   ONE_Q16  = 17'd65536;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd65536;

    localparam logic [1:0] MODE_VERTEX    = 2'd0;
    localparam logic [1:0] MODE_EDGE_ALL  = 2'd1;
    localparam logic [1:0] MODE_EDGE_OWN  = 2'd2;
    localparam logic [1:0] MODE_EDGE_PRES = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic signed [31:0] centre_value;
        logic signed [31:0] neighbour_value_0;
        logic signed [31:0] neighbour_value_1;
        logic signed [31:0] neighbour_value_2;
        logic [2:0]        neighbour_present;
        logic signed [31:0] face_value_0;
        logic signed [31:0] face_value_1;
        logic signed [31:0] face_value_2;
        logic signed [31:0] slope_x_in;
        logic signed [31:0] slope_y_in;
        logic              last_in;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] vertex_out_0;
        logic signed [31:0] vertex_out_1;
        logic signed [31:0] vertex_out_2;
        logic signed [31:0] edge_out_0;
        logic signed [31:0] edge_out_1;
        logic signed [31:0] edge_out_2;
        logic signed [31:0] slope_x_out;
        logic signed [31:0] slope_y_out;
        logic [16:0]       limit_factor;
        logic              last_out;
    } t_out_word;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        qc;
        logic [2:0]         dneg;
        logic [2:0]         dzero;
        logic [2:0]         skip;
        logic [2:0][31:0]   dmag;
        logic [2:0][31:0]   amag;
        logic [31:0]        gx;
        logic [31:0]        gy;
        logic               last;
    } t_cls_word;

    function automatic logic [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sd2147483647);
        lo = -WIDE_W'(64'sd2147483648);
        if (v > hi) begin
            return 32'h7FFF_FFFF;
        end else if (v < lo) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- rtl/triangle_slope_limiter_top.sv -----
// ============================================================================
// triangle_slope_limiter_top
// Minmod-style slope limiter for one triangle per cycle.
// ----------------------------------------------------------------------------
//  channel   | ports                        | handshake
//  ----------+------------------------------+--------------------------------
//  command   | i_start, o_busy, i_word      | taken when i_start & !o_busy
//  result    | o_done, o_word               | one-cycle strobe, no backpressure
//  config    | i_cfg_wr, i_cfg_data         | written when i_cfg_wr
//
//  One triangle is taken per cycle while o_busy is low; each result passes
//  the 16-step pipelined ratio dividers (one quotient bit per stage).
//  Reset clears all valid flags and loads r_gain with 1.0.
//  o_busy rises only when the front-to-back queue is nearly full; the back
//  never stalls, so in steady use the block is never busy.
// ============================================================================
module triangle_slope_limiter_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  tsl_pkg::t_in_word               i_word,
    input  logic                            i_cfg_wr,
    input  logic [tsl_pkg::GAIN_W-1:0]      i_cfg_data,
    output logic                            o_done,
    output tsl_pkg::t_out_word              o_word
);
    import tsl_pkg::*;

    logic [GAIN_W-1:0] r_gain;
    logic              accept;
    logic              push;
    t_cls_word         cls;
    logic              q_vld;
    t_cls_word         q_data;

    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_wr) begin
            r_gain <= i_cfg_data;
        end
    end

    tsl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_word),
        .o_push   (push),
        .o_cls    (cls)
    );

    tsl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (cls),
        .o_vld    (q_vld),
        .o_data   (q_data),
        .o_busy   (o_busy)
    );

    tsl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (q_vld),
        .i_cls    (q_data),
        .i_gain   (r_gain),
        .o_done   (o_done),
        .o_word   (o_word)
    );

    a_phi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_word.limit_factor <= ONE_Q16))
        else $error("limit factor above one");

    a_busy_needs_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> q_vld)
        else $error("busy with empty queue");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_done)
        else $error("result strobe right after reset");

endmodule

// ----- rtl/tsl_front.sv -----
// ============================================================================
// tsl_front
// Input register and classification: deviations, allowed deviations, flags.
// ============================================================================
module tsl_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  tsl_pkg::t_in_word   i_word,
    output logic                o_push,
    output tsl_pkg::t_cls_word  o_cls
);
    import tsl_pkg::*;

    logic      r_vld;
    t_in_word  r_in;

    logic signed [31:0] qc;
    logic signed [31:0] qn   [3];
    logic signed [31:0] face [3];
    logic signed [31:0] qmin, qmax;
    logic signed [31:0] nv   [3];
    logic signed [31:0] lo   [3];
    logic signed [31:0] hi   [3];
    logic signed [32:0] dq   [3];
    logic signed [32:0] ndq  [3];
    logic signed [32:0] up   [3];
    logic signed [32:0] dn   [3];
    logic               own;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_accept;
        end
        if (i_accept) begin
            r_in <= i_word;
        end
    end

    assign qc      = r_in.centre_value;
    assign qn[0]   = r_in.neighbour_value_0;
    assign qn[1]   = r_in.neighbour_value_1;
    assign qn[2]   = r_in.neighbour_value_2;
    assign face[0] = r_in.face_value_0;
    assign face[1] = r_in.face_value_1;
    assign face[2] = r_in.face_value_2;
    assign own     = (r_in.mode == MODE_EDGE_OWN) || (r_in.mode == MODE_EDGE_PRES);

    always_comb begin
        qmin = qc;
        qmax = qc;
        for (int i = 0; i < 3; i++) begin
            if (r_in.neighbour_present[i]) begin
                if (qn[i] < qmin) qmin = qn[i];
                if (qn[i] > qmax) qmax = qn[i];
            end
        end
    end

    always_comb begin
        o_cls      = '0;
        o_cls.mode = r_in.mode;
        o_cls.qc   = qc;
        o_cls.gx   = r_in.slope_x_in;
        o_cls.gy   = r_in.slope_y_in;
        o_cls.last = r_in.last_in;
        for (int i = 0; i < 3; i++) begin
            nv[i]  = r_in.neighbour_present[i] ? qn[i] : qc;
            lo[i]  = own ? ((nv[i] < qc) ? nv[i] : qc) : qmin;
            hi[i]  = own ? ((nv[i] > qc) ? nv[i] : qc) : qmax;
            dq[i]  = 33'(face[i]) - 33'(qc);
            ndq[i] = -dq[i];
            up[i]  = 33'(hi[i]) - 33'(qc);
            dn[i]  = 33'(qc) - 33'(lo[i]);
            o_cls.dneg[i]  = dq[i][32];
            o_cls.dzero[i] = (dq[i] == '0);
            o_cls.skip[i]  = (r_in.mode == MODE_EDGE_PRES) && !r_in.neighbour_present[i];
            o_cls.dmag[i]  = dq[i][32] ? ndq[i][31:0] : dq[i][31:0];
            o_cls.amag[i]  = dq[i][32] ? dn[i][31:0] : up[i][31:0];
        end
    end

    assign o_push = r_vld;

endmodule

// ----- rtl/tsl_queue.sv -----
// ============================================================================
// tsl_queue
// Short queue between the classification front and the limiter back.
// ============================================================================
module tsl_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tsl_pkg::t_cls_word  i_data,
    output logic                o_vld,
    output tsl_pkg::t_cls_word  o_data,
    output logic                o_busy
);
    import tsl_pkg::*;

    t_cls_word          r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wp, r_rp;
    logic [QPTR_W:0]    r_cnt;
    logic               pop;

    assign pop    = (r_cnt != '0);
    assign o_vld  = pop;
    assign o_data = r_mem[r_rp];
    assign o_busy = (r_cnt >= (QPTR_W+1)'(QDEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (pop)    r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- rtl/tsl_back.sv -----
// ============================================================================
// tsl_back
// Ratio division pipelines, phi minimum, scaling, rebuild and saturation.
// ============================================================================
module tsl_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    input  tsl_pkg::t_cls_word              i_cls,
    input  logic [tsl_pkg::GAIN_W-1:0]      i_gain,
    output logic                            o_done,
    output tsl_pkg::t_out_word              o_word
);
    import tsl_pkg::*;

    typedef struct packed {
        t_cls_word          p;
        logic [2:0][49:0]   n;
        logic [16:0]        gmin;
    } t_mul_stage;

    typedef struct packed {
        t_cls_word          p;
        logic [2:0]         cap;
        logic [2:0][31:0]   rem;
        logic [2:0][15:0]   low;
        logic [2:0][15:0]   q;
        logic [16:0]        gmin;
    } t_div_stage;

    typedef struct packed {
        t_cls_word          p;
        logic [16:0]        phi;
    } t_phi_stage;

    typedef struct packed {
        t_cls_word          p;
        logic [16:0]        phi;
        logic [2:0][32:0]   sm;
        logic [32:0]        gxm;
        logic [32:0]        gym;
    } t_scl_stage;

    typedef struct packed {
        logic [1:0]             mode;
        logic [16:0]            phi;
        logic [2:0][35:0]       sc;
        logic [35:0]            gxo;
        logic [35:0]            gyo;
        logic                   last;
    } t_sum_stage;

    typedef struct packed {
        logic [2:0][35:0]       v;
        logic [2:0][35:0]       e;
        logic [35:0]            gxo;
        logic [35:0]            gyo;
        logic [16:0]            phi;
        logic                   last;
    } t_rec_stage;

    t_mul_stage  r_a;
    logic        r_av;
    t_div_stage  r_d  [QUOT_W+1];
    logic        r_dv [QUOT_W+1];
    t_phi_stage  r_c;
    logic        r_cv;
    t_scl_stage  r_s;
    logic        r_sv;
    t_sum_stage  r_e;
    logic        r_ev;
    t_rec_stage  r_f;
    logic        r_fv;

    t_mul_stage  n_a;
    t_div_stage  n_d0;
    t_phi_stage  n_c;
    t_scl_stage  n_s;
    t_sum_stage  n_e;
    t_rec_stage  n_f;
    t_out_word   n_o;

    logic [16:0] cand [3];
    logic [31:0] gxn, gyn;
    logic signed [35:0] sv [3];
    logic signed [35:0] ev [3];

    always_comb begin
        n_a.p    = i_cls;
        n_a.gmin = (i_gain > GAIN_W'(ONE_Q16)) ? ONE_Q16 : i_gain[16:0];
        for (int i = 0; i < 3; i++) begin
            n_a.n[i] = 50'(i_gain) * 50'(i_cls.amag[i]);
        end
    end

    always_comb begin
        n_d0.p    = r_a.p;
        n_d0.gmin = r_a.gmin;
        n_d0.q    = '0;
        for (int i = 0; i < 3; i++) begin
            n_d0.cap[i] = r_a.n[i] >= {2'b00, r_a.p.dmag[i], 16'h0000};
            n_d0.rem[i] = r_a.n[i][47:16];
            n_d0.low[i] = r_a.n[i][15:0];
        end
    end

    for (genvar k = 0; k < QUOT_W; k++) begin : g_div
        t_div_stage  n_step;
        logic [32:0] t   [3];
        logic [32:0] sub [3];
        always_comb begin
            n_step = r_d[k];
            for (int i = 0; i < 3; i++) begin
                t[i]   = {r_d[k].rem[i], r_d[k].low[i][15]};
                sub[i] = t[i] - {1'b0, r_d[k].p.dmag[i]};
                n_step.low[i] = {r_d[k].low[i][14:0], 1'b0};
                if (t[i] >= {1'b0, r_d[k].p.dmag[i]}) begin
                    n_step.rem[i] = sub[i][31:0];
                    n_step.q[i]   = {r_d[k].q[i][14:0], 1'b1};
                end else begin
                    n_step.rem[i] = t[i][31:0];
                    n_step.q[i]   = {r_d[k].q[i][14:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else begin
                r_dv[k+1] <= r_dv[k];
            end
            r_d[k+1] <= n_step;
        end
    end

    always_comb begin
        n_c.p   = r_d[QUOT_W].p;
        n_c.phi = ONE_Q16;
        for (int i = 0; i < 3; i++) begin
            if (r_d[QUOT_W].p.skip[i] || r_d[QUOT_W].cap[i]) begin
                cand[i] = ONE_Q16;
            end else if (r_d[QUOT_W].p.dzero[i]) begin
                cand[i] = r_d[QUOT_W].gmin;
            end else begin
                cand[i] = {1'b0, r_d[QUOT_W].q[i]};
            end
            if (r_d[QUOT_W].p.dzero[i] && !r_d[QUOT_W].p.skip[i]) begin
                cand[i] = r_d[QUOT_W].gmin;
            end
            if (cand[i] < n_c.phi) n_c.phi = cand[i];
        end
    end

    always_comb begin
        n_s.p   = r_c.p;
        n_s.phi = r_c.phi;
        gxn     = -r_c.p.gx;
        gyn     = -r_c.p.gy;
        for (int i = 0; i < 3; i++) begin
            n_s.sm[i] = 33'((49'(r_c.p.dmag[i]) * 49'(r_c.phi)) >> 16);
        end
        n_s.gxm = 33'((49'(r_c.p.gx[31] ? gxn : r_c.p.gx) * 49'(r_c.phi)) >> 16);
        n_s.gym = 33'((49'(r_c.p.gy[31] ? gyn : r_c.p.gy) * 49'(r_c.phi)) >> 16);
    end

    always_comb begin
        n_e.mode = r_s.p.mode;
        n_e.phi  = r_s.phi;
        n_e.last = r_s.p.last;
        for (int i = 0; i < 3; i++) begin
            sv[i] = r_s.p.dneg[i] ? -$signed(36'(r_s.sm[i])) : $signed(36'(r_s.sm[i]));
            n_e.sc[i] = $signed(36'($signed(r_s.p.qc))) + sv[i];
        end
        if (!r_s.p.mode[1]) begin
            n_e.gxo = r_s.p.gx[31] ? -36'(r_s.gxm) : 36'(r_s.gxm);
            n_e.gyo = r_s.p.gy[31] ? -36'(r_s.gym) : 36'(r_s.gym);
        end else begin
            n_e.gxo = 36'($signed(r_s.p.gx));
            n_e.gyo = 36'($signed(r_s.p.gy));
        end
    end

    always_comb begin
        n_f.gxo  = r_e.gxo;
        n_f.gyo  = r_e.gyo;
        n_f.phi  = r_e.phi;
        n_f.last = r_e.last;
        for (int i = 0; i < 3; i++) begin
            ev[i] = $signed(r_e.sc[i]);
        end
        if (r_e.mode == MODE_VERTEX) begin
            n_f.v    = r_e.sc;
            n_f.e[0] = 36'((ev[1] + ev[2]) >>> 1);
            n_f.e[1] = 36'((ev[2] + ev[0]) >>> 1);
            n_f.e[2] = 36'((ev[0] + ev[1]) >>> 1);
        end else begin
            n_f.e    = r_e.sc;
            n_f.v[0] = 36'(ev[1] + ev[2] - ev[0]);
            n_f.v[1] = 36'(ev[2] + ev[0] - ev[1]);
            n_f.v[2] = 36'(ev[0] + ev[1] - ev[2]);
        end
    end

    always_comb begin
        n_o.vertex_out_0 = sat32($signed(r_f.v[0]));
        n_o.vertex_out_1 = sat32($signed(r_f.v[1]));
        n_o.vertex_out_2 = sat32($signed(r_f.v[2]));
        n_o.edge_out_0   = sat32($signed(r_f.e[0]));
        n_o.edge_out_1   = sat32($signed(r_f.e[1]));
        n_o.edge_out_2   = sat32($signed(r_f.e[2]));
        n_o.slope_x_out  = sat32($signed(r_f.gxo));
        n_o.slope_y_out  = sat32($signed(r_f.gyo));
        n_o.limit_factor = r_f.phi;
        n_o.last_out     = r_f.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av    <= 1'b0;
            r_dv[0] <= 1'b0;
            r_cv    <= 1'b0;
            r_sv    <= 1'b0;
            r_ev    <= 1'b0;
            r_fv    <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            r_av    <= i_vld;
            r_dv[0] <= r_av;
            r_cv    <= r_dv[QUOT_W];
            r_sv    <= r_cv;
            r_ev    <= r_sv;
            r_fv    <= r_ev;
            o_done  <= r_fv;
        end
        r_a    <= n_a;
        r_d[0] <= n_d0;
        r_c    <= n_c;
        r_s    <= n_s;
        r_e    <= n_e;
        r_f    <= n_f;
        o_word <= n_o;
    end

endmodule
